[rtl/zel_pkg.sv]
`timescale 1ns / 1ps
// zel_pkg: shared types and constants for the zero-export inverter limiter
// no dependencies

package zel_pkg;

    localparam int POW_W   = 12;
    localparam int METER_W = 16;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 18;
    localparam int IDX_W   = 3;
    localparam int QDEPTH  = 2;
    localparam int QAW     = 1;
    localparam int QCW     = 2;

    localparam logic [1:0] OP_REGULATE = 2'd0;
    localparam logic [1:0] OP_SET      = 2'd1;
    localparam logic [1:0] OP_SEND     = 2'd2;

    localparam logic REG_ZX_ENABLE = 1'b0;
    localparam logic REG_MAX_WATT  = 1'b1;

    localparam logic [POW_W-1:0] POWER_LIMIT = 12'd3000;
    localparam logic [POW_W-1:0] OUT_MAX     = 12'd4095;

    localparam logic signed [METER_W-1:0] IMPORT_THRESH = 16'sd20;
    localparam logic signed [SUM_W-1:0]   DEAD_BAND     = 18'sd10;

    localparam logic [BYTE_W-1:0] FB_START = 8'h24;
    localparam logic [BYTE_W-1:0] FB_ADDR  = 8'h56;
    localparam logic [BYTE_W-1:0] FB_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] FB_CMD   = 8'h21;
    localparam logic [BYTE_W-1:0] FB_TAIL  = 8'h80;
    localparam logic [BYTE_W-1:0] CS_INIT  = 8'hFF;
    localparam logic [BYTE_W-1:0] CS_BASE  =
        8'(CS_INIT - FB_ADDR - FB_ZERO - FB_CMD - FB_TAIL);

    localparam logic [IDX_W-1:0] IDX_HI   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_LO   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    typedef struct packed {
        logic             valid;
        logic [POW_W-1:0] power;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/zel_ifs.sv]
`timescale 1ns / 1ps
// zel channel interfaces: item input, frame output, config write
// depends on zel_pkg

interface zel_in_if;
    import zel_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic signed [METER_W-1:0] meter_power;
    logic [POW_W-1:0]          new_power;
    modport source(output valid, op, meter_power, new_power, input ready);
    modport sink(input valid, op, meter_power, new_power, output ready);
endinterface

interface zel_out_if;
    import zel_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              last_byte;
    modport source(output valid, frame_byte, last_byte, input ready);
    modport sink(input valid, frame_byte, last_byte, output ready);
endinterface

interface zel_cfg_if;
    import zel_pkg::*;
    logic             valid;
    logic             ready;
    logic             index;
    logic [POW_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[rtl/zel_front.sv]
`timescale 1ns / 1ps
// zel_front: accepts items, holds config and power state, queues send requests
// depends on zel_pkg and zel_ifs

module zel_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    zel_in_if.sink           i_item,
    zel_cfg_if.sink          i_cfg,
    input  zel_pkg::t_q_stat i_qstat,
    output zel_pkg::t_q_entry o_push
);
    import zel_pkg::*;

    logic                    r_zx_en;
    logic [POW_W-1:0]        r_max_watt;
    logic [POW_W-1:0]        r_reg_out;
    logic [POW_W-1:0]        r_cmd_pow;
    logic [POW_W-1:0]        n_reg_out;
    logic [POW_W-1:0]        n_cmd_pow;
    logic                    w_accept;
    logic                    w_import;
    logic                    w_export;
    logic signed [SUM_W-1:0] w_sum;

    assign i_item.ready = !i_qstat.full;
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_import = i_item.meter_power > IMPORT_THRESH;
    assign w_export = i_item.meter_power[METER_W-1];
    assign w_sum = $signed({{(SUM_W-POW_W){1'b0}}, r_reg_out})
                 + SUM_W'(i_item.meter_power)
                 + (w_import ? -DEAD_BAND : DEAD_BAND);

    always_comb begin
        n_reg_out = r_reg_out;
        n_cmd_pow = r_cmd_pow;
        if (w_accept) begin
            case (i_item.op)
                OP_REGULATE: begin
                    if (r_zx_en) begin
                        if (w_import) begin
                            if (w_sum >= $signed({{(SUM_W-POW_W){1'b0}}, r_max_watt})) begin
                                n_reg_out = r_max_watt;
                            end else begin
                                n_reg_out = w_sum[POW_W-1:0];
                            end
                        end else if (w_export) begin
                            if (w_sum < 0) begin
                                n_reg_out = '0;
                            end else if (w_sum > $signed({{(SUM_W-POW_W){1'b0}}, OUT_MAX})) begin
                                n_reg_out = OUT_MAX;
                            end else begin
                                n_reg_out = w_sum[POW_W-1:0];
                            end
                        end
                        n_cmd_pow = n_reg_out;
                    end
                end
                OP_SET: begin
                    if (i_item.new_power <= POWER_LIMIT) begin
                        n_cmd_pow = i_item.new_power;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zx_en    <= 1'b0;
            r_max_watt <= '0;
            r_reg_out  <= '0;
            r_cmd_pow  <= '0;
        end else begin
            r_reg_out <= n_reg_out;
            r_cmd_pow <= n_cmd_pow;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ZX_ENABLE: r_zx_en    <= i_cfg.data[0];
                    REG_MAX_WATT:  r_max_watt <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_push.valid = w_accept && (i_item.op == OP_SEND);
    assign o_push.power = r_cmd_pow;

    a_set_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_item.op == OP_SET && i_item.new_power <= POWER_LIMIT
        |=> r_cmd_pow == $past(i_item.new_power))
        else $error("accepted set did not load commanded power");

    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_item.op == OP_REGULATE && !r_zx_en |=> $stable(r_reg_out))
        else $error("regulate changed output while disabled");

endmodule

[rtl/zel_queue.sv]
`timescale 1ns / 1ps
// zel_queue: short fifo of commanded-power snapshots between front and back
// depends on zel_pkg

module zel_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zel_pkg::t_q_entry i_push,
    input  logic              i_pop,
    output zel_pkg::t_q_entry o_head,
    output zel_pkg::t_q_stat  o_stat
);
    import zel_pkg::*;

    logic [POW_W-1:0] r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_stat.full  = r_cnt == QCW'(QDEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign w_push = i_push.valid && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    assign o_head.valid = !o_stat.empty;
    assign o_head.power = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_push.power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_stat.full)
        else $error("send pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH))
        else $error("queue count out of range");

endmodule

[rtl/zel_back.sv]
`timescale 1ns / 1ps
// zel_back: serializes one queued power value into the 8-byte rs485 frame
// depends on zel_pkg and zel_ifs

module zel_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  zel_pkg::t_q_entry i_head,
    output logic              o_pop,
    zel_out_if.source         o_frame
);
    import zel_pkg::*;

    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_hi;
    logic [BYTE_W-1:0] r_lo;
    logic [BYTE_W-1:0] r_cs;
    logic [BYTE_W-1:0] w_hi;
    logic [BYTE_W-1:0] w_lo;
    logic              w_step;
    logic              w_done;

    assign w_hi   = BYTE_W'(i_head.power >> BYTE_W);
    assign w_lo   = i_head.power[BYTE_W-1:0];
    assign w_step = r_busy && o_frame.ready;
    assign w_done = w_step && (r_idx == IDX_LAST);
    assign o_pop  = i_head.valid && (!r_busy || w_done);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hi <= w_hi;
            r_lo <= w_lo;
            r_cs <= CS_BASE - w_hi - w_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (w_step) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_comb begin
        case (r_idx)
            3'd0:    o_frame.frame_byte = FB_START;
            3'd1:    o_frame.frame_byte = FB_ADDR;
            3'd2:    o_frame.frame_byte = FB_ZERO;
            3'd3:    o_frame.frame_byte = FB_CMD;
            IDX_HI:  o_frame.frame_byte = r_hi;
            IDX_LO:  o_frame.frame_byte = r_lo;
            3'd6:    o_frame.frame_byte = FB_TAIL;
            default: o_frame.frame_byte = r_cs;
        endcase
    end

    assign o_frame.valid     = r_busy;
    assign o_frame.last_byte = r_idx == IDX_LAST;

    a_pop_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_busy && r_idx == '0)
        else $error("pop did not start a new frame");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_frame.ready |=> r_busy && $stable(r_idx))
        else $error("frame advanced while stalled");

endmodule

[rtl/zero_export_inverter_limiter.sv]
`timescale 1ns / 1ps
// zero_export_inverter_limiter: one item per cycle while the send queue has room
// regulate and set transactions take effect at the accepting edge, no output
// a send emits 8 bytes, first byte valid once the send is queued and then popped into the back's frame registers
// frames stream back to back at one byte per cycle while o_frame.ready is high
// synchronous active-low reset clears config, power state and the queue
// depends on zel_pkg, zel_ifs, zel_front, zel_queue, zel_back

module zero_export_inverter_limiter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    zel_in_if.sink    i_item,
    zel_cfg_if.sink   i_cfg,
    zel_out_if.source o_frame
);
    import zel_pkg::*;

    t_q_entry w_push;
    t_q_entry w_head;
    t_q_stat  w_qstat;
    logic     w_pop;

    zel_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (i_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push)
    );

    zel_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    zel_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_frame (o_frame)
    );

endmodule
